>>> rtl/core/dspp_pkg.sv
// ----------------------------------------------------------------------------
// dspp_pkg
// Shared constants for the delta-state packet parser: parse phases, byte
// roles, packet status codes and the fixed field sizes of the packet format.
// ----------------------------------------------------------------------------
package dspp_pkg;

    // Parse phase codes (plain vector state).
    localparam logic [1:0] PH_HDR   = 2'd0;
    localparam logic [1:0] PH_ENT   = 2'd1;
    localparam logic [1:0] PH_PAY   = 2'd2;
    localparam logic [1:0] PH_TRAIL = 2'd3;

    // Role of each byte on the result channel.
    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
    localparam logic [1:0] KIND_TRAILING = 2'd2;

    // Packet status reported on the closing byte.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_SHORT     = 2'd1;
    localparam logic [1:0] STAT_CUT_EHDR  = 2'd2;
    localparam logic [1:0] STAT_CUT_PAY   = 2'd3;

    // Field sizes in bytes, at the width of the field byte counter.
    localparam logic [3:0] HDR_BYTES      = 4'd4;
    localparam logic [3:0] SNAP_BYTES     = 4'd2;
    localparam logic [3:0] ID_BYTES       = 4'd8;
    localparam logic [3:0] ENT_HDR_BYTES  = 4'd10;

endpackage

>>> rtl/core/delta_state_packet_parser.sv
// ----------------------------------------------------------------------------
// delta_state_packet_parser
// Byte-serial parser for delta-state packets: header, entity headers and
// payload, with newest-snapshot tracking and an end-of-packet status.
// ----------------------------------------------------------------------------
// The parser takes one packet byte per clock and returns exactly one result
// per byte, in the cycle after the byte is accepted, so a continuous stream runs
// at one byte per clock. The parse state advances as each byte is accepted and
// the result lands in an output register; a new byte is taken whenever that
// register is empty or is being drained in the same cycle, so only
// backpressure on the result channel slows the input. Each packet opens with a
// big-endian 16-bit snapshot id and 16-bit entity count, then per entity a
// 64-bit id, a 16-bit length and that many payload bytes; bytes past the
// counted entities come back marked as trailing. The newest snapshot id is
// kept across packets by 16-bit serial-number order and survives packet ends.
module delta_state_packet_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_packet_last,
    // Result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_byte_kind,
    output logic [7:0]  o_payload_byte,
    output logic [63:0] o_entity_id,
    output logic [15:0] o_payload_offset,
    output logic [15:0] o_entity_length,
    output logic        o_entity_done,
    output logic [15:0] o_snapshot_number,
    output logic [15:0] o_entity_total,
    output logic [15:0] o_newest_snapshot,
    output logic [1:0]  o_packet_status,
    output logic        o_packet_end
);

    // Parse state
    logic [1:0]  r_phase,     n_phase;
    logic [3:0]  r_field_cnt, n_field_cnt;
    logic [15:0] r_snap,      n_snap;
    logic [15:0] r_ent_cnt,   n_ent_cnt;
    logic [15:0] r_parsed,    n_parsed;
    logic [63:0] r_id,        n_id;
    logic [15:0] r_len,       n_len;
    logic [15:0] r_pos,       n_pos;
    logic [15:0] r_newest,    n_newest;

    // Result register
    logic        r_out_valid;
    logic [1:0]  r_kind,   n_kind;
    logic [7:0]  r_pay,    n_pay;
    logic [63:0] r_eid,    n_eid;
    logic [15:0] r_off,    n_off;
    logic [15:0] r_elen,   n_elen;
    logic        r_done,   n_done;
    logic [15:0] r_osnap;
    logic [15:0] r_ototal;
    logic [15:0] r_onewest;
    logic [1:0]  r_status, n_status;
    logic        r_end;

    logic        w_in_acc;
    logic [3:0]  w_cnt_inc;
    logic [63:0] w_id_base;
    logic [15:0] w_len_base;
    logic [15:0] w_parsed_inc;
    logic [15:0] w_pos_inc;
    logic [15:0] w_snap_diff;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_in_acc = i_valid && o_ready;

    assign w_cnt_inc    = r_field_cnt + 4'd1;
    assign w_parsed_inc = r_parsed + 16'd1;
    assign w_pos_inc    = r_pos + 16'd1;
    assign w_id_base    = (r_field_cnt == 4'd0) ? 64'd0 : r_id;
    assign w_len_base   = (r_field_cnt == 4'd0) ? 16'd0 : r_len;

    always_comb begin
        n_phase     = r_phase;
        n_field_cnt = r_field_cnt;
        n_snap      = r_snap;
        n_ent_cnt   = r_ent_cnt;
        n_parsed    = r_parsed;
        n_id        = r_id;
        n_len       = r_len;
        n_pos       = r_pos;
        n_newest    = r_newest;
        n_kind      = dspp_pkg::KIND_HEADER;
        n_pay       = 8'd0;
        n_eid       = 64'd0;
        n_off       = 16'd0;
        n_elen      = 16'd0;
        n_done      = 1'b0;
        n_status    = dspp_pkg::STAT_OK;
        w_snap_diff = 16'd0;

        case (r_phase)
            dspp_pkg::PH_HDR: begin
                if (r_field_cnt < dspp_pkg::SNAP_BYTES) begin
                    n_snap = {r_snap[7:0], i_data_byte};
                end else begin
                    n_ent_cnt = {r_ent_cnt[7:0], i_data_byte};
                end
                n_field_cnt = w_cnt_inc;
                if (w_cnt_inc == dspp_pkg::HDR_BYTES) begin
                    n_field_cnt = 4'd0;
                    // Serial-number order: take the new id when it lies ahead
                    // by 1 to 32767 modulo 2^16.
                    w_snap_diff = n_snap - r_newest;
                    if (w_snap_diff != 16'd0 && !w_snap_diff[15]) begin
                        n_newest = n_snap;
                    end
                    n_phase = (n_ent_cnt != 16'd0) ? dspp_pkg::PH_ENT : dspp_pkg::PH_TRAIL;
                end
            end
            dspp_pkg::PH_ENT: begin
                if (r_field_cnt < dspp_pkg::ID_BYTES) begin
                    n_id  = {w_id_base[55:0], i_data_byte};
                    n_len = w_len_base;
                end else begin
                    n_id  = w_id_base;
                    n_len = {w_len_base[7:0], i_data_byte};
                end
                n_field_cnt = w_cnt_inc;
                n_eid       = n_id;
                n_elen      = n_len;
                if (w_cnt_inc == dspp_pkg::ENT_HDR_BYTES) begin
                    n_field_cnt = 4'd0;
                    n_pos       = 16'd0;
                    if (n_len == 16'd0) begin
                        // An empty entity closes on its last header byte.
                        n_done   = 1'b1;
                        n_parsed = w_parsed_inc;
                        n_phase  = (w_parsed_inc == r_ent_cnt) ? dspp_pkg::PH_TRAIL
                                                               : dspp_pkg::PH_ENT;
                    end else begin
                        n_phase = dspp_pkg::PH_PAY;
                    end
                end
            end
            dspp_pkg::PH_PAY: begin
                n_kind = dspp_pkg::KIND_PAYLOAD;
                n_pay  = i_data_byte;
                n_eid  = r_id;
                n_elen = r_len;
                n_off  = r_pos;
                n_pos  = w_pos_inc;
                if (w_pos_inc == r_len) begin
                    n_done   = 1'b1;
                    n_parsed = w_parsed_inc;
                    n_phase  = (w_parsed_inc == r_ent_cnt) ? dspp_pkg::PH_TRAIL
                                                           : dspp_pkg::PH_ENT;
                end
            end
            default: begin
                n_kind = dspp_pkg::KIND_TRAILING;
            end
        endcase

        if (i_packet_last) begin
            case (n_phase)
                dspp_pkg::PH_HDR: n_status = dspp_pkg::STAT_SHORT;
                dspp_pkg::PH_ENT: n_status = dspp_pkg::STAT_CUT_EHDR;
                dspp_pkg::PH_PAY: n_status = dspp_pkg::STAT_CUT_PAY;
                default:          n_status = dspp_pkg::STAT_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dspp_pkg::PH_HDR;
            r_field_cnt <= 4'd0;
            r_snap      <= 16'd0;
            r_ent_cnt   <= 16'd0;
            r_parsed    <= 16'd0;
            r_id        <= 64'd0;
            r_len       <= 16'd0;
            r_pos       <= 16'd0;
            r_newest    <= 16'd0;
        end else if (w_in_acc) begin
            r_newest <= n_newest;
            if (i_packet_last) begin
                // Everything but the newest snapshot starts over per packet.
                r_phase     <= dspp_pkg::PH_HDR;
                r_field_cnt <= 4'd0;
                r_snap      <= 16'd0;
                r_ent_cnt   <= 16'd0;
                r_parsed    <= 16'd0;
                r_id        <= 64'd0;
                r_len       <= 16'd0;
                r_pos       <= 16'd0;
            end else begin
                r_phase     <= n_phase;
                r_field_cnt <= n_field_cnt;
                r_snap      <= n_snap;
                r_ent_cnt   <= n_ent_cnt;
                r_parsed    <= n_parsed;
                r_id        <= n_id;
                r_len       <= n_len;
                r_pos       <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind    <= n_kind;
            r_pay     <= n_pay;
            r_eid     <= n_eid;
            r_off     <= n_off;
            r_elen    <= n_elen;
            r_done    <= n_done;
            r_osnap   <= n_snap;
            r_ototal  <= n_ent_cnt;
            r_onewest <= n_newest;
            r_status  <= n_status;
            r_end     <= i_packet_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_byte_kind       = r_kind;
    assign o_payload_byte    = r_pay;
    assign o_entity_id       = r_eid;
    assign o_payload_offset  = r_off;
    assign o_entity_length   = r_elen;
    assign o_entity_done     = r_done;
    assign o_snapshot_number = r_osnap;
    assign o_entity_total    = r_ototal;
    assign o_newest_snapshot = r_onewest;
    assign o_packet_status   = r_status;
    assign o_packet_end      = r_end;

    // A closing byte always leaves the parser at the start of a new packet.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_packet_last) |=> (r_phase == dspp_pkg::PH_HDR && r_field_cnt == 4'd0))
        else $error("parse state not cleared after packet end");

    // A byte taken in the payload phase comes back as payload.
    a_pay_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_phase == dspp_pkg::PH_PAY) |=>
            (o_valid && o_byte_kind == dspp_pkg::KIND_PAYLOAD))
        else $error("payload byte not tagged as payload");

    // Payload offsets stay inside the declared entity length.
    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_kind == dspp_pkg::KIND_PAYLOAD) |->
            (o_payload_offset < o_entity_length))
        else $error("payload offset beyond entity length");

    // Status is only reported on the byte that closes the packet.
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_packet_end) |-> (o_packet_status == dspp_pkg::STAT_OK))
        else $error("status reported before packet end");

    // The header byte counter never runs past the packet header.
    a_hdr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dspp_pkg::PH_HDR) |-> (r_field_cnt < dspp_pkg::HDR_BYTES))
        else $error("header byte count out of range");

endmodule
